// ----- rtl/core/dssq_pkg.sv -----
`timescale 1ns / 1ps

package dssq_pkg;

    // Item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Axis direction codes; the fourth code runs without moving the phase
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [7:0] FAST_THRESHOLD_RST = 8'd5;

    typedef logic [2:0] t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] dir;
        logic [7:0] rem;
        logic [3:0] coils;
    } t_axis;

    // Half-step coil nibble for each phase
    function automatic logic [3:0] coil_nibble(input t_phase phase);
        logic [3:0] nib;
        case (phase)
            3'd0:    nib = 4'h8;
            3'd1:    nib = 4'h9;
            3'd2:    nib = 4'h1;
            3'd3:    nib = 4'h5;
            3'd4:    nib = 4'h4;
            3'd5:    nib = 4'h6;
            3'd6:    nib = 4'h2;
            3'd7:    nib = 4'hA;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    // One tick of one axis: spend budget, move phase, give the coil nibble
    function automatic t_axis axis_tick(input t_phase phase, input logic [1:0] dir,
                                        input logic [7:0] rem, input logic [7:0] thr);
        t_axis  res;
        t_phase step;
        res.phase = phase;
        res.dir   = dir;
        res.rem   = rem;
        res.coils = 4'h0;
        if (rem == 8'd0) begin
            res.dir = DIR_STOP;
        end else begin
            res.rem = rem - 8'd1;
            step    = (res.rem > thr) ? 3'd2 : 3'd1;
            if (dir == DIR_UP) begin
                res.phase = phase + step;
            end else if (dir == DIR_DOWN) begin
                res.phase = phase - step;
            end
            res.coils = coil_nibble(res.phase);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/dual_stepper_half_step_sequencer.sv -----
`timescale 1ns / 1ps

// Two-axis unipolar stepper sequencer, half-step mode. Every accepted input word
// gives exactly one result word. A command word (i_kind = 1) loads direction and
// step budget into whichever axes have their load bit set and returns an empty
// result. A tick word (i_kind = 0) returns a zero coil byte with o_frame_valid
// set when both axes are stopped; otherwise each axis with budget spends one
// step and moves two half-steps while more than the fast threshold remain, one
// after that, and the coil byte (x high nibble, y low nibble) is flagged valid
// only when it differs from the last byte sent. o_x_running / o_y_running show
// each axis's state after the word. The block takes one word per cycle while the
// result register is free or draining: a word is held in the input register,
// the tick logic runs between that register and the result register, and ready
// stays high as long as that holds. The threshold register (reset 5) is always
// ready and should be written only while idle.
module dual_stepper_half_step_sequencer
    import dssq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input word
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic       i_x_load,
    input  logic [1:0] i_x_dir,
    input  logic [7:0] i_x_count,
    input  logic       i_y_load,
    input  logic [1:0] i_y_dir,
    input  logic [7:0] i_y_count,
    // result word
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_frame_valid,
    output logic [7:0] o_frame,
    output logic       o_x_running,
    output logic       o_y_running,
    // threshold write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    // input register
    logic       r_in_vld;
    logic       r_kind, r_x_load, r_y_load;
    logic [1:0] r_x_dir_in, r_y_dir_in;
    logic [7:0] r_x_count, r_y_count;

    // axis and frame state
    t_phase     r_x_phase, r_y_phase;
    logic [1:0] r_x_dir, r_y_dir;
    logic [7:0] r_x_rem, r_y_rem;
    logic [7:0] r_last_frame;
    logic [7:0] r_thr;

    // result register
    logic       r_out_vld;
    logic       r_frame_valid;
    logic [7:0] r_frame;
    logic       r_x_running, r_y_running;

    logic       out_free, advance;

    t_phase     n_x_phase, n_y_phase;
    logic [1:0] n_x_dir, n_y_dir;
    logic [7:0] n_x_rem, n_y_rem;
    logic [7:0] n_last_frame;
    logic       n_frame_valid;
    logic [7:0] n_frame;
    t_axis      x_step, y_step;
    logic [7:0] coil_byte;

    // Result register can take a word when empty or being emptied this cycle
    assign out_free   = !r_out_vld || i_out_ready;
    assign advance    = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid   = r_out_vld;
    assign o_frame_valid = r_frame_valid;
    assign o_frame       = r_frame;
    assign o_x_running   = r_x_running;
    assign o_y_running   = r_y_running;

    assign x_step    = axis_tick(r_x_phase, r_x_dir, r_x_rem, r_thr);
    assign y_step    = axis_tick(r_y_phase, r_y_dir, r_y_rem, r_thr);
    assign coil_byte = {x_step.coils, y_step.coils};

    always_comb begin
        n_x_phase     = r_x_phase;
        n_y_phase     = r_y_phase;
        n_x_dir       = r_x_dir;
        n_y_dir       = r_y_dir;
        n_x_rem       = r_x_rem;
        n_y_rem       = r_y_rem;
        n_last_frame  = r_last_frame;
        n_frame_valid = 1'b0;
        n_frame       = 8'h00;
        if (r_kind == KIND_CMD) begin
            // load the selected axes, send nothing
            if (r_x_load) begin
                n_x_dir = r_x_dir_in;
                n_x_rem = r_x_count;
            end
            if (r_y_load) begin
                n_y_dir = r_y_dir_in;
                n_y_rem = r_y_count;
            end
        end else if (r_x_dir == DIR_STOP && r_y_dir == DIR_STOP) begin
            // both idle: send a zero byte, leave the last-sent byte alone
            n_frame_valid = 1'b1;
        end else begin
            n_x_phase = x_step.phase;
            n_x_dir   = x_step.dir;
            n_x_rem   = x_step.rem;
            n_y_phase = y_step.phase;
            n_y_dir   = y_step.dir;
            n_y_rem   = y_step.rem;
            // drop a byte that repeats the last one sent
            if (coil_byte != r_last_frame) begin
                n_last_frame  = coil_byte;
                n_frame_valid = 1'b1;
                n_frame       = coil_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_x_phase    <= '0;
            r_y_phase    <= '0;
            r_x_dir      <= DIR_STOP;
            r_y_dir      <= DIR_STOP;
            r_x_rem      <= '0;
            r_y_rem      <= '0;
            r_last_frame <= '0;
            r_thr        <= FAST_THRESHOLD_RST;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            // hold the input register until the result register frees up
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_x_phase    <= n_x_phase;
                r_y_phase    <= n_y_phase;
                r_x_dir      <= n_x_dir;
                r_y_dir      <= n_y_dir;
                r_x_rem      <= n_x_rem;
                r_y_rem      <= n_y_rem;
                r_last_frame <= n_last_frame;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind     <= i_kind;
            r_x_load   <= i_x_load;
            r_x_dir_in <= i_x_dir;
            r_x_count  <= i_x_count;
            r_y_load   <= i_y_load;
            r_y_dir_in <= i_y_dir;
            r_y_count  <= i_y_count;
        end
        if (advance) begin
            r_frame_valid <= n_frame_valid;
            r_frame       <= n_frame;
            r_x_running   <= (n_x_dir != DIR_STOP);
            r_y_running   <= (n_y_dir != DIR_STOP);
        end
    end

endmodule
